### hdl/htd_pkg.sv
package htd_pkg;

  // Field widths
  localparam int IDX_W     = 9;
  localparam int LETTER_W  = 8;
  localparam int BYTE_W    = 8;
  localparam int COUNT_W   = 32;
  localparam int BIT_CNT_W = $clog2(BYTE_W);

  localparam int DEFAULT_TABLE_DEPTH = 512;

  // Opcodes of an input beat
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_DECODE  = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // One tree node: letter, left child, right child (left of zero marks a leaf)
  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic [IDX_W-1:0]    left;
    logic [IDX_W-1:0]    right;
  } node_t;

endpackage

### hdl/huffman_table_tree_decoder.sv
// Channel  Handshake          Beat contents
// -------  -----------------  ------------------------------------------------
// in       in_valid/in_ready  opcode, entry_index/letter/left/right, data_byte
// out      out_valid/out_ready out_letter, last_in_run, stream_done
// cfg      cfg_we             cfg_wdata -> total_bytes
//
// Load, restart and ignored beats leave in_ready high. A decode beat fetches the
// current node in its accept cycle, then keeps in_ready low while it fetches
// the first child, tests each bit, refetches the root for each letter found
// before the last bit and flushes the last letter, so the next beat is not
// taken until the byte is done; the letter limit can end the byte early.
// Every bit waits on the node read of the bit before.
// rst clears the walk state, letter count and total_bytes; the table itself is not
// cleared. A stalled out channel holds the walk at the next letter.
module huffman_table_tree_decoder
  import htd_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          opcode,
  input  logic [IDX_W-1:0]    entry_index,
  input  logic [LETTER_W-1:0] entry_letter,
  input  logic [IDX_W-1:0]    entry_left,
  input  logic [IDX_W-1:0]    entry_right,
  input  logic [BYTE_W-1:0]   data_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [LETTER_W-1:0] out_letter,
  output logic                last_in_run,
  output logic                stream_done,
  input  logic                cfg_we,
  input  logic [COUNT_W-1:0]  cfg_wdata
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_STEP  = 2'd1;
  localparam logic [1:0] S_TEST  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]           state;
  logic [IDX_W-1:0]     node_ptr;
  logic [IDX_W-1:0]     child_q;
  logic [BYTE_W-1:0]    byte_q;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [COUNT_W-1:0]   letters;
  logic [COUNT_W-1:0]   total_bytes;
  logic                 finished;
  logic                 pend_valid;
  logic [LETTER_W-1:0]  pend_letter;
  logic                 pend_done;

  logic                 in_accept;
  logic                 out_ok;
  logic                 wr_en;
  node_t                wr_node;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_index;
  node_t                rd_node;
  logic [IDX_W-1:0]     step_child;
  logic                 leaf;
  logic                 leaf_go;
  logic                 last_bit;
  logic [COUNT_W-1:0]   letters_next;
  logic                 hit_total;
  logic                 push;
  logic                 push_last;

  htd_node_ram #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_index(entry_index),
    .wr_node (wr_node),
    .rd_en   (rd_en),
    .rd_index(rd_index),
    .rd_node (rd_node)
  );

  assign in_ready  = (state == S_IDLE) && !pend_valid;
  assign in_accept = in_valid && in_ready;
  assign out_ok    = !out_valid || out_ready;

  assign wr_node.letter = entry_letter;
  assign wr_node.left   = entry_left;
  assign wr_node.right  = entry_right;

  // Shared step unit: child select on the msb, leaf test, letter count
  assign step_child   = byte_q[BYTE_W-1] ? rd_node.left : rd_node.right;
  assign leaf         = (rd_node.left == '0);
  assign leaf_go      = leaf && (!pend_valid || out_ok);
  assign last_bit     = (bit_cnt == BIT_CNT_W'(BYTE_W - 1));
  assign letters_next = letters + COUNT_W'(1);
  assign hit_total    = (total_bytes != '0) && (letters_next == total_bytes);

  // Table port control and output pushes
  always_comb begin
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    rd_index  = node_ptr;
    push      = 1'b0;
    push_last = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_accept && opcode == OP_LOAD) begin
          wr_en = 1'b1;
        end
        if (in_accept && opcode == OP_DECODE && !finished) begin
          rd_en = 1'b1;
        end
      end
      S_STEP: begin
        rd_en    = 1'b1;
        rd_index = step_child;
      end
      S_TEST: begin
        if (leaf) begin
          if (leaf_go) begin
            push = pend_valid;
            if (!hit_total && !last_bit) begin
              rd_en    = 1'b1;
              rd_index = '0;
            end
          end
        end else if (!last_bit) begin
          rd_en    = 1'b1;
          rd_index = step_child;
        end
      end
      S_FLUSH: begin
        push      = pend_valid && out_ok;
        push_last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer and walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      node_ptr   <= '0;
      letters    <= '0;
      finished   <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            if (opcode == OP_RESTART) begin
              node_ptr <= '0;
              letters  <= '0;
              finished <= 1'b0;
            end else if (opcode == OP_DECODE && !finished) begin
              state <= S_STEP;
            end
          end
        end
        S_STEP: begin
          state <= S_TEST;
        end
        S_TEST: begin
          if (leaf) begin
            if (leaf_go) begin
              pend_valid <= 1'b1;
              letters    <= letters_next;
              node_ptr   <= '0;
              if (hit_total) begin
                finished <= 1'b1;
                state    <= S_FLUSH;
              end else if (last_bit) begin
                state <= S_FLUSH;
              end else begin
                state <= S_STEP;
              end
            end
          end else begin
            node_ptr <= child_q;
            if (last_bit) begin
              state <= S_FLUSH;
            end
          end
        end
        S_FLUSH: begin
          if (!pend_valid || out_ok) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Bit shifter, bit count, child index and pending letter
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_accept) begin
      byte_q  <= data_byte;
      bit_cnt <= '0;
    end else if (state == S_STEP) begin
      child_q <= step_child;
      byte_q  <= {byte_q[BYTE_W-2:0], 1'b0};
    end else if (state == S_TEST) begin
      if (leaf) begin
        if (leaf_go) begin
          pend_letter <= rd_node.letter;
          pend_done   <= hit_total;
          bit_cnt     <= bit_cnt + BIT_CNT_W'(1);
        end
      end else begin
        child_q <= step_child;
        byte_q  <= {byte_q[BYTE_W-2:0], 1'b0};
        bit_cnt <= bit_cnt + BIT_CNT_W'(1);
      end
    end
  end

  // Total letter count register
  always_ff @(posedge clk) begin
    if (rst) begin
      total_bytes <= '0;
    end else if (cfg_we) begin
      total_bytes <= cfg_wdata;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_letter  <= pend_letter;
      last_in_run <= push_last;
      stream_done <= pend_done;
    end
  end

endmodule

### hdl/htd_node_ram.sv
module htd_node_ram
  import htd_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_index,
  input  node_t            wr_node,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_index,
  output node_t            rd_node
);

  localparam int AW = $clog2(TABLE_DEPTH);

  node_t mem [TABLE_DEPTH];
  node_t rd_q;
  logic  rd_hit;

  logic wr_in_range;
  logic rd_in_range;

  assign wr_in_range = 32'(wr_index) < TABLE_DEPTH;
  assign rd_in_range = 32'(rd_index) < TABLE_DEPTH;

  // Write port: entries past the table are dropped
  always_ff @(posedge clk) begin
    if (wr_en && wr_in_range) begin
      mem[AW'(wr_index)] <= wr_node;
    end
  end

  // Registered read; an index past the table reads as an all-zero leaf
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_hit <= rd_in_range;
      if (rd_in_range) begin
        rd_q <= mem[AW'(rd_index)];
      end
    end
  end

  assign rd_node = rd_hit ? rd_q : '0;

endmodule
